FILE: rtl/core/text_console_cursor_engine_core_defines.svh
// ----------------------------------------------------------------------------
// text console cursor engine: assertion macros
// concurrent assertion helpers clocked on clk_i and held off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every edge
`define TCCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tcce assertion failed");

// consequent holds in the same cycle as the antecedent
`define TCCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcce implication failed");

// consequent holds in the cycle after the antecedent
`define TCCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcce next-cycle implication failed");

`else

`define TCCE_ASSERT(lbl, prop)
`define TCCE_ASSERT_IMP(lbl, ante, cons)
`define TCCE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// geometry, codes, control word layout and microprogram of the cursor engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcce_pkg;

  // screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned CELL_W = 16;

  // last address of the row copy and of the whole screen
  localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELLS - 1);

  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t S_BOOT   = 4'd0;
  localparam step_t S_IDLE   = 4'd1;
  localparam step_t S_PUTC   = 4'd2;
  localparam step_t S_NL     = 4'd3;
  localparam step_t S_CR     = 4'd4;
  localparam step_t S_TAB    = 4'd5;
  localparam step_t S_BS     = 4'd6;
  localparam step_t S_BSW    = 4'd7;
  localparam step_t S_CLR    = 4'd8;
  localparam step_t S_HOME   = 4'd9;
  localparam step_t S_RD     = 4'd10;
  localparam step_t S_CHKSCR = 4'd11;
  localparam step_t S_SCR0   = 4'd12;
  localparam step_t S_SCRCP  = 4'd13;
  localparam step_t S_SCRBL  = 4'd14;
  localparam step_t S_FIN    = 4'd15;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_ADV, CUR_NL, CUR_CR, CUR_TAB, CUR_BACK, CUR_HOME, CUR_LASTROW
  } cur_op_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_CHAR_AT_CUR, WR_BLANK_AT_CUR, WR_BLANK_AT_ADDR, WR_COPY_AT_ADDR,
    WR_RESET_AT_ADDR
  } wr_op_e;

  typedef enum logic [1:0] {
    RD_NONE, RD_IDX, RD_ROW, RD_ROW_NEXT
  } rd_op_e;

  typedef enum logic [1:0] {
    ADDR_HOLD, ADDR_ZERO, ADDR_INC
  } addr_op_e;

  // C_DISPATCH and C_FIN wait in place; the rest jump when true, else step on
  typedef enum logic [2:0] {
    C_NEXT, C_JUMP, C_HOME, C_ROW_OK, C_NE_COPY, C_NE_LAST, C_DISPATCH, C_FIN
  } cond_e;

  typedef struct packed {
    cur_op_e  cur;
    wr_op_e   wr;
    rd_op_e   rd;
    addr_op_e addr;
    logic     set_scroll;
    cond_e    cond;
    step_t    target;
  } ctrl_t;

  // request from the sequencer to the screen store
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } scr_req_t;

  localparam ctrl_t CTRL_NOP = '{
    cur: CUR_HOLD, wr: WR_NONE, rd: RD_NONE, addr: ADDR_HOLD,
    set_scroll: 1'b0, cond: C_NEXT, target: S_BOOT
  };

  // control store
  function automatic ctrl_t ucode(step_t step);
    ctrl_t w;
    w = CTRL_NOP;
    case (step)
      S_BOOT: begin
        w.wr = WR_RESET_AT_ADDR; w.addr = ADDR_INC;
        w.cond = C_NE_LAST; w.target = S_BOOT;
      end
      S_IDLE: begin
        w.addr = ADDR_ZERO; w.cond = C_DISPATCH;
      end
      S_PUTC: begin
        w.wr = WR_CHAR_AT_CUR; w.cur = CUR_ADV;
        w.cond = C_JUMP; w.target = S_CHKSCR;
      end
      S_NL: begin
        w.cur = CUR_NL; w.cond = C_JUMP; w.target = S_CHKSCR;
      end
      S_CR: begin
        w.cur = CUR_CR; w.cond = C_JUMP; w.target = S_FIN;
      end
      S_TAB: begin
        w.cur = CUR_TAB; w.cond = C_JUMP; w.target = S_CHKSCR;
      end
      S_BS: begin
        w.cur = CUR_BACK; w.cond = C_HOME; w.target = S_FIN;
      end
      S_BSW: begin
        w.wr = WR_BLANK_AT_CUR; w.cond = C_JUMP; w.target = S_FIN;
      end
      S_CLR: begin
        w.wr = WR_BLANK_AT_ADDR; w.addr = ADDR_INC;
        w.cond = C_NE_LAST; w.target = S_CLR;
      end
      S_HOME: begin
        w.cur = CUR_HOME; w.cond = C_JUMP; w.target = S_FIN;
      end
      S_RD: begin
        w.rd = RD_IDX; w.cond = C_JUMP; w.target = S_FIN;
      end
      S_CHKSCR: begin
        w.cond = C_ROW_OK; w.target = S_FIN;
      end
      S_SCR0: begin
        w.cur = CUR_LASTROW; w.set_scroll = 1'b1; w.rd = RD_ROW;
      end
      S_SCRCP: begin
        w.wr = WR_COPY_AT_ADDR; w.rd = RD_ROW_NEXT; w.addr = ADDR_INC;
        w.cond = C_NE_COPY; w.target = S_SCRCP;
      end
      S_SCRBL: begin
        w.wr = WR_BLANK_AT_ADDR; w.addr = ADDR_INC;
        w.cond = C_NE_LAST; w.target = S_SCRBL;
      end
      S_FIN: begin
        w.cond = C_FIN;
      end
      default: begin
        w = CTRL_NOP;
      end
    endcase
    return w;
  endfunction

  // entry point of the routine for one beat
  function automatic step_t dispatch(logic [1:0] op, logic [7:0] ch);
    step_t s;
    case (op)
      OP_PUT: begin
        case (ch)
          CH_NL:   s = S_NL;
          CH_CR:   s = S_CR;
          CH_BS:   s = S_BS;
          CH_TAB:  s = S_TAB;
          default: s = S_PUTC;
        endcase
      end
      OP_CLEAR: s = S_CLR;
      OP_READ:  s = S_RD;
      default:  s = S_FIN;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/core/tcce_screen.sv
// ----------------------------------------------------------------------------
// tcce_screen
// character cell store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcce_screen import tcce_pkg::*; (
  input  logic              clk_i,
  input  scr_req_t          req_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  // accesses past the last cell are dropped
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr < IDX_W'(CELLS))) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re && (req_i.raddr < IDX_W'(CELLS))) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/text_console_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// 80 x 25 character cell terminal with cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
// one beat in, one result beat out. a microcoded sequencer steps through a
// small control store; every routine enters from the idle step and leaves
// through a finish step that loads the output register, so a new beat is
// taken as soon as the previous result is parked there. a put, newline or
// tab that runs off the bottom row scrolls: one pass over the cell store,
// which has one write and one read port, copies 1920 cells and blanks 80.
// clear sweeps all 2000 cells. after reset the block blanks the store with
// the reset attribute in one pass over all cells before it takes its
// first beat; the attribute register may be written at any time while no
// beat is in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_cursor_engine_core_defines.svh"

module text_console_cursor_engine_core import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // attribute register
  input  logic              text_attr_we_i,
  input  logic [7:0]        text_attr_i,
  // command beats
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        char_code_i,
  input  logic [IDX_W-1:0]  cell_index_i,
  // result beats
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [IDX_W-1:0]  cursor_pos_o,
  output logic [CELL_W-1:0] cell_data_o,
  output logic              scrolled_o
);

  // sequencer state
  step_t upc_q, upc_d;
  ctrl_t ctrl;

  // datapath registers
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic [7:0]        attr_q;
  logic              scr_q;

  // latched command
  logic [1:0]        op_q;
  logic [7:0]        ch_q;
  logic [IDX_W-1:0]  idx_q;

  // result register
  logic              out_valid_q;
  logic [COL_W-1:0]  res_col_q;
  logic [ROW_W-1:0]  res_row_q;
  logic [IDX_W-1:0]  res_pos_q;
  logic [CELL_W-1:0] res_data_q;
  logic              res_scr_q;

  logic              in_acc;
  logic              out_free;
  logic              fin_load;
  logic              at_home;
  logic [IDX_W-1:0]  cur_lin;
  logic [COL_W:0]    tab_sum;
  logic [COL_W:0]    tab_col;
  logic [CELL_W-1:0] blank;
  logic [CELL_W-1:0] rdata;
  logic [CELL_W-1:0] res_data;
  scr_req_t          scr_req;

  assign ctrl     = ucode(upc_q);
  assign in_acc   = (upc_q == S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_load = (upc_q == S_FIN) && out_free;
  assign at_home  = (col_q == '0) && (row_q == '0);
  assign blank    = {attr_q, SPACE_CHAR};

  // linear cursor address, row times 80 plus column
  assign cur_lin = IDX_W'(row_q) * IDX_W'(COLUMNS) + IDX_W'(col_q);

  // next tab stop: round up to the following multiple of eight
  assign tab_sum = {1'b0, col_q} + (COL_W+1)'(8);
  assign tab_col = {tab_sum[COL_W:3], 3'b000};

  // step counter with conditional jumps
  always_comb begin
    case (ctrl.cond)
      C_NEXT:     upc_d = upc_q + step_t'(1);
      C_JUMP:     upc_d = ctrl.target;
      C_HOME:     upc_d = at_home ? ctrl.target : upc_q + step_t'(1);
      C_ROW_OK:   upc_d = (row_q < ROW_W'(ROWS)) ? ctrl.target : upc_q + step_t'(1);
      C_NE_COPY:  upc_d = (addr_q != COPY_LAST) ? ctrl.target : upc_q + step_t'(1);
      C_NE_LAST:  upc_d = (addr_q != CELL_LAST) ? ctrl.target : upc_q + step_t'(1);
      C_DISPATCH: upc_d = in_valid_i ? dispatch(opcode_i, char_code_i) : upc_q;
      C_FIN:      upc_d = out_free ? S_IDLE : upc_q;
      default:    upc_d = S_IDLE;
    endcase
  end

  // cursor update; a wrap off the row end moves down one row
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    case (ctrl.cur)
      CUR_HOLD: ;
      CUR_ADV: begin
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
      CUR_NL: begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end
      CUR_CR: col_d = '0;
      CUR_TAB: begin
        if (tab_col >= (COL_W+1)'(COLUMNS)) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = tab_col[COL_W-1:0];
        end
      end
      CUR_BACK: begin
        // top-left leaves the cursor alone
        if (col_q != '0) begin
          col_d = col_q - COL_W'(1);
        end else if (row_q != '0) begin
          col_d = COL_W'(COLUMNS - 1);
          row_d = row_q - ROW_W'(1);
        end
      end
      CUR_HOME: begin
        col_d = '0;
        row_d = '0;
      end
      CUR_LASTROW: row_d = ROW_W'(ROWS - 1);
      default: ;
    endcase
  end

  // sweep pointer
  always_comb begin
    case (ctrl.addr)
      ADDR_HOLD: addr_d = addr_q;
      ADDR_ZERO: addr_d = '0;
      ADDR_INC:  addr_d = addr_q + IDX_W'(1);
      default:   addr_d = addr_q;
    endcase
  end

  // cell store request
  always_comb begin
    scr_req = '0;
    case (ctrl.wr)
      WR_NONE: ;
      WR_CHAR_AT_CUR: begin
        scr_req.we    = 1'b1;
        scr_req.waddr = cur_lin;
        scr_req.wdata = {attr_q, ch_q};
      end
      WR_BLANK_AT_CUR: begin
        scr_req.we    = 1'b1;
        scr_req.waddr = cur_lin;
        scr_req.wdata = blank;
      end
      WR_BLANK_AT_ADDR: begin
        scr_req.we    = 1'b1;
        scr_req.waddr = addr_q;
        scr_req.wdata = blank;
      end
      WR_COPY_AT_ADDR: begin
        // read data holds the cell one row further down
        scr_req.we    = 1'b1;
        scr_req.waddr = addr_q;
        scr_req.wdata = rdata;
      end
      WR_RESET_AT_ADDR: begin
        // boot sweep always uses the reset attribute
        scr_req.we    = 1'b1;
        scr_req.waddr = addr_q;
        scr_req.wdata = {RESET_ATTR, SPACE_CHAR};
      end
      default: ;
    endcase
    case (ctrl.rd)
      RD_NONE: ;
      RD_IDX: begin
        scr_req.re    = 1'b1;
        scr_req.raddr = idx_q;
      end
      RD_ROW: begin
        scr_req.re    = 1'b1;
        scr_req.raddr = addr_q + IDX_W'(COLUMNS);
      end
      RD_ROW_NEXT: begin
        scr_req.re    = 1'b1;
        scr_req.raddr = addr_q + IDX_W'(COLUMNS + 1);
      end
      default: ;
    endcase
  end

  tcce_screen u_screen (
    .clk_i   (clk_i),
    .req_i   (scr_req),
    .rdata_o (rdata)
  );

  // only an in-range read reports a cell
  assign res_data = ((op_q == OP_READ) && (idx_q < IDX_W'(CELLS))) ? rdata : '0;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= S_BOOT;
      col_q       <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      attr_q      <= RESET_ATTR;
      scr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      col_q  <= col_d;
      row_q  <= row_d;
      addr_q <= addr_d;
      if (text_attr_we_i) begin
        attr_q <= text_attr_i;
      end
      if (in_acc) begin
        scr_q <= 1'b0;
      end else if (ctrl.set_scroll) begin
        scr_q <= 1'b1;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
    end
    if (fin_load) begin
      res_col_q  <= col_q;
      res_row_q  <= row_q;
      res_pos_q  <= cur_lin;
      res_data_q <= res_data;
      res_scr_q  <= scr_q;
    end
  end

  assign in_stall_o   = (upc_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = res_col_q;
  assign cursor_row_o = res_row_q;
  assign cursor_pos_o = res_pos_q;
  assign cell_data_o  = res_data_q;
  assign scrolled_o   = res_scr_q;

  // cursor is always on screen between beats
  `TCCE_ASSERT_IMP(a_cursor_on_screen, upc_q == S_IDLE, (col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
  // an accepted beat always starts a routine
  `TCCE_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && !in_stall_o, upc_q != S_IDLE)
  // finish step with a free output register presents a result
  `TCCE_ASSERT_NXT(a_fin_loads_result, fin_load, out_valid_o)
  // the row copy stays above the last row
  `TCCE_ASSERT_IMP(a_copy_in_bounds, upc_q == S_SCRCP, addr_q <= COPY_LAST)
  // scroll is only entered with the cursor below the last row
  `TCCE_ASSERT_IMP(a_scroll_needed, upc_q == S_SCR0, row_q == ROW_W'(ROWS))

endmodule

FILE: dv/text_console_cursor_engine_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core_tb
// self-checking bench for the 80 x 25 cursor engine: directed table, random
// command streams under several attributes, random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cursor_engine_core_tb;
  import tcce_pkg::*;

  // opcode 3 has no name in the package, it is a no-op that reports the cursor
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // cycles with no beat moving on either channel before the run is abandoned
  localparam int STALL_LIMIT = 12000;
  localparam int PRESSURE_HOLD = 400;
  localparam int PRESSURE_AT = 250;
  localparam int PHASE_BEATS = 160;

  // one result beat, field for field
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [IDX_W-1:0]  pos;
    logic [CELL_W-1:0] data;
    logic              scr;
  } cursor_beat_t;

  // one line of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic [1:0]        op;
    logic [7:0]        ch;
    logic [IDX_W-1:0]  idx;
    int                reps;
    bit                typed;
    cursor_beat_t      want;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              text_attr_we_i = 1'b0;
  logic [7:0]        text_attr_i = 8'h00;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        opcode_i = OP_PUT;
  logic [7:0]        char_code_i = 8'h00;
  logic [IDX_W-1:0]  cell_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [COL_W-1:0]  cursor_col_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [IDX_W-1:0]  cursor_pos_o;
  logic [CELL_W-1:0] cell_data_o;
  logic              scrolled_o;

  text_console_cursor_engine_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_attr_we_i (text_attr_we_i),
    .text_attr_i    (text_attr_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .char_code_i    (char_code_i),
    .cell_index_i   (cell_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_pos_o   (cursor_pos_o),
    .cell_data_o    (cell_data_o),
    .scrolled_o     (scrolled_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the terminal: screen, cursor and attribute
  logic [CELL_W-1:0] shadow_cells [CELLS];
  logic [COL_W-1:0]  shadow_col;
  logic [ROW_W-1:0]  shadow_row;
  logic [7:0]        shadow_attr;

  cursor_beat_t cursor_beats_due[$];
  stim_row_t    directed_rows[$];

  int  mismatches = 0;
  int  beats_seen = 0;
  int  quiet_cycles = 0;
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;
  bit  pressure_done = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
    mismatches++;
  endtask

  // blank the whole shadow screen with the current attribute
  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      shadow_cells[i] = {shadow_attr, SPACE_CHAR};
    end
  endtask

  // advance the shadow terminal by one command and give the result it reports
  task automatic console_step(input logic [1:0] op, input logic [7:0] ch,
                              input logic [IDX_W-1:0] idx, output cursor_beat_t res);
    int c;
    int r;
    logic [CELL_W-1:0] blank;
    res = '0;
    blank = {shadow_attr, SPACE_CHAR};
    c = int'(shadow_col);
    r = int'(shadow_row);
    case (op)
      OP_PUT: begin
        if (ch == CH_NL) begin
          c = 0;
          r++;
        end else if (ch == CH_CR) begin
          c = 0;
        end else if (ch == CH_BS) begin
          // at top-left nothing moves and nothing is blanked
          if (c > 0 || r > 0) begin
            if (c == 0) begin
              r--;
              c = COLUMNS - 1;
            end else begin
              c--;
            end
            shadow_cells[r * COLUMNS + c] = blank;
          end
        end else if (ch == CH_TAB) begin
          c = (c + 8) & ~7;
        end else begin
          shadow_cells[r * COLUMNS + c] = {shadow_attr, ch};
          c++;
        end
        // wrap at the end of a row
        if (c >= COLUMNS) begin
          c = 0;
          r++;
        end
        // run off the bottom: shift up one row, blank the last row
        if (r >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            shadow_cells[i] = shadow_cells[i + COLUMNS];
          end
          for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
            shadow_cells[i] = blank;
          end
          r = ROWS - 1;
          res.scr = 1'b1;
        end
      end
      OP_CLEAR: begin
        blank_screen();
        c = 0;
        r = 0;
      end
      OP_READ: begin
        // indexes past the screen read as zero
        if (idx < CELLS) begin
          res.data = shadow_cells[idx];
        end
      end
      default: begin
      end
    endcase
    shadow_col = COL_W'(c);
    shadow_row = ROW_W'(r);
    res.col = shadow_col;
    res.row = shadow_row;
    res.pos = IDX_W'(r * COLUMNS + c);
  endtask

  // offer one command beat; the beat is predicted once in_stall_o is seen low after an edge
  task automatic send_beat(input logic [1:0] op, input logic [7:0] ch,
                           input logic [IDX_W-1:0] idx, input bit typed,
                           input cursor_beat_t want);
    int gap;
    cursor_beat_t predicted;
    gap = send_idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    console_step(op, ch, idx, predicted);
    cursor_beats_due.push_back(typed ? want : predicted);
  endtask

  // directed table rows; typed rows all sit at home, so only data is given
  task automatic add_row(input logic [1:0] op, input logic [7:0] ch,
                         input logic [IDX_W-1:0] idx, input int reps,
                         input bit typed, input logic [CELL_W-1:0] data);
    stim_row_t row;
    row.op = op;
    row.ch = ch;
    row.idx = idx;
    row.reps = reps;
    row.typed = typed;
    row.want = '0;
    row.want.data = data;
    directed_rows.push_back(row);
  endtask

  // attribute writes only once the pipe has drained
  task automatic set_text_attr(input logic [7:0] value);
    in_valid_i <= 1'b0;
    while (cursor_beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    text_attr_we_i <= 1'b1;
    text_attr_i    <= value;
    @(posedge clk_i);
    text_attr_we_i <= 1'b0;
    shadow_attr = value;
  endtask

  // watchdog: counts edges where neither channel moves a beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stall per beat, one long hold-off to back the block up
  initial begin : result_sink
    cursor_beat_t got;
    cursor_beat_t want;
    int hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = recv_idle_on ? $urandom_range(0, 17) : 0;
      if (!pressure_done && beats_seen >= PRESSURE_AT) begin
        hold = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.col  = cursor_col_o;
      got.row  = cursor_row_o;
      got.pos  = cursor_pos_o;
      got.data = cell_data_o;
      got.scr  = scrolled_o;
      beats_seen++;
      if (cursor_beats_due.size() == 0) begin
        report_mismatch("result with nothing due", int'(got.pos), 0);
      end else begin
        want = cursor_beats_due.pop_front();
        if (got.col !== want.col)
          report_mismatch("cursor_col", int'(got.col), int'(want.col));
        if (got.row !== want.row)
          report_mismatch("cursor_row", int'(got.row), int'(want.row));
        if (got.pos !== want.pos)
          report_mismatch("cursor_pos", int'(got.pos), int'(want.pos));
        if (got.data !== want.data)
          report_mismatch("cell_data", int'(got.data), int'(want.data));
        if (got.scr !== want.scr)
          report_mismatch("scrolled", int'(got.scr), int'(want.scr));
      end
    end
  end

  initial begin : command_source
    logic [1:0]       op;
    logic [7:0]       ch;
    logic [IDX_W-1:0] idx;
    logic [7:0]       attr;
    int               pick;

    // shadow comes up as the block does after its boot sweep
    shadow_attr = RESET_ATTR;
    shadow_col = '0;
    shadow_row = '0;
    blank_screen();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // freshly booted screen, out of range read, no-op and backspace at home
    add_row(OP_READ,   8'h00,  11'd0,       1, 1'b1, {RESET_ATTR, SPACE_CHAR});
    add_row(OP_READ,   8'hFF,  CELL_LAST,   1, 1'b1, {RESET_ATTR, SPACE_CHAR});
    add_row(OP_READ,   8'h00,  11'h7FF,     1, 1'b1, 16'h0000);
    add_row(OP_UNUSED, 8'hFF,  11'h7FF,     1, 1'b1, 16'h0000);
    add_row(OP_PUT,    CH_BS,  11'd0,       1, 1'b1, 16'h0000);
    // printable extremes, then the control codes
    add_row(OP_PUT,    8'h41,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_PUT,    8'hFF,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_PUT,    8'h00,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_READ,   8'h00,  11'd1,       1, 1'b0, 16'h0000);
    add_row(OP_PUT,    CH_TAB, 11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_PUT,    CH_CR,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_PUT,    CH_NL,  11'd0,       1, 1'b0, 16'h0000);
    // backspace at column 0 climbs to the last column of the row above
    add_row(OP_PUT,    CH_BS,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_READ,   8'h00,  11'd79,      1, 1'b0, 16'h0000);
    // put in the last column wraps to the next row
    add_row(OP_PUT,    8'h5A,  11'd0,       1, 1'b0, 16'h0000);
    // tabs that run past the row end
    add_row(OP_PUT,    CH_TAB, 11'd0,      10, 1'b0, 16'h0000);
    // down to the bottom row, then a tab wrap that scrolls
    add_row(OP_PUT,    CH_NL,  11'd0,      22, 1'b0, 16'h0000);
    add_row(OP_PUT,    CH_TAB, 11'd0,      10, 1'b0, 16'h0000);
    // printable wrap off the last cell scrolls
    add_row(OP_PUT,    CH_TAB, 11'd0,       9, 1'b0, 16'h0000);
    add_row(OP_PUT,    8'h7E,  11'd0,       8, 1'b0, 16'h0000);
    // newline on the bottom row scrolls
    add_row(OP_PUT,    CH_NL,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_READ,   8'h00,  11'd1840,    1, 1'b0, 16'h0000);
    add_row(OP_READ,   8'h00,  11'd1920,    1, 1'b0, 16'h0000);
    add_row(OP_CLEAR,  8'h00,  11'd0,       1, 1'b0, 16'h0000);
    add_row(OP_READ,   8'h00,  CELL_LAST,   1, 1'b1, {RESET_ATTR, SPACE_CHAR});

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        send_beat(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random streams; first two phases take the attribute extremes
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) attr = 8'h00;
      else if (phase == 1) attr = 8'hFF;
      else attr = 8'($urandom_range(1, 254));
      set_text_attr(attr);
      // one phase with no idling, one with idling on both sides, rest mixed
      if (phase == 0) begin
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
      end else if (phase == 1) begin
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
      end else begin
        send_idle_on = 1'($urandom_range(0, 1));
        recv_idle_on = 1'($urandom_range(0, 1));
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        pick = $urandom_range(0, 99);
        op = OP_PUT;
        ch = 8'($urandom_range(0, 255));
        idx = IDX_W'($urandom_range(0, CELLS - 1));
        if (pick < 55) begin
          // any byte, control codes included now and then
        end else if (pick < 63) begin
          ch = CH_NL;
        end else if (pick < 66) begin
          ch = CH_CR;
        end else if (pick < 72) begin
          ch = CH_BS;
        end else if (pick < 77) begin
          ch = CH_TAB;
        end else if (pick < 79) begin
          op = OP_CLEAR;
        end else if (pick < 97) begin
          op = OP_READ;
          // lean towards the cursor row where the writing happens
          if ($urandom_range(0, 1) == 0) begin
            idx = IDX_W'(shadow_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
          end
          if ($urandom_range(0, 6) == 0) begin
            idx = IDX_W'($urandom_range(CELLS, 2047));
          end
        end else begin
          op = OP_UNUSED;
        end
        send_beat(op, ch, idx, 1'b0, '0);
      end
    end

    // drain, then give the block time to show any stray result
    in_valid_i <= 1'b0;
    while (cursor_beats_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
